[rtl/cht_pkg.sv]
// ============================================================================
// Hash table package
// Shared field widths, action and status codes, and the beat types of the
// input and result channels.
// ============================================================================
package cht_pkg;

    // Fixed field widths.
    localparam int KEY_W        = 31;
    localparam int KEY_CNT_W    = $clog2(KEY_W);
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 3;
    localparam int BUCKET_OUT_W = 6;
    localparam int POS_OUT_W    = 3;
    localparam int CFG_W        = 7;

    // Bucket count after reset.
    localparam logic [CFG_W-1:0] RESET_BUCKET_COUNT = 7'd10;

    // Action codes. The unused code behaves as a search.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEL_FAILED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    // Input beat.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [KEY_W-1:0]        key_echo;
        logic [STATUS_W-1:0]     status;
        logic [BUCKET_OUT_W-1:0] bucket;
        logic [POS_OUT_W-1:0]    position;
    } out_item_t;

endpackage

[rtl/cht_ram.sv]
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module cht_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/cht_mod.sv]
// ============================================================================
// Iterative modulo unit
// Restoring division of a key by a small divisor, one quotient bit per
// cycle; only the remainder is kept.
// ============================================================================
module cht_mod #(
    parameter int DIV_W = 7
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [cht_pkg::KEY_W-1:0] dividend,
    input  logic [DIV_W-1:0]         divisor,
    output logic                     done,
    output logic [DIV_W-1:0]         remainder
);

    localparam int KW = cht_pkg::KEY_W;
    localparam int CW = cht_pkg::KEY_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] num_reg, num_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] rem_reg, rem_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;

    // One restoring step: bring down the next dividend bit and subtract
    // the divisor when it fits.
    assign trial = {rem_reg, num_reg[KW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            num_next = {num_reg[KW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(KW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[rtl/chained_hash_table.sv]
// ============================================================================
// Chained hash table
// Hash table with fixed-depth buckets: insert at the front, search for the
// first match, delete the first match and close the gap.
// ============================================================================
// A key goes to bucket (key mod bucket_count), where bucket_count is clamped
// to 1..NUM_BUCKETS. Each item yields one result beat. The modulo runs one
// bit per cycle in the restoring unit cht_mod, which then flags completion.
// The bucket fill count then costs one RAM read. After that the sequencer
// walks the bucket through the single read port of the key RAM, reading and
// then writing or comparing each entry: an insert moves fill entries back,
// a search compares up to fill entries, a delete compares up to the match
// and then moves the tail forward. The result is then loaded into the
// output register, and the next input beat can be accepted in the same
// cycle that the result beat appears. The block takes one item at a time
// and may accept the next one while the previous result still waits; a
// finished item then holds the sequencer until the output register is
// free. After reset a clearing pass zeroes the bucket fill counts, one
// bucket per cycle, during which no item is accepted; bucket_count writes
// are taken at any time.
module chained_hash_table #(
    parameter int NUM_BUCKETS = 64,
    parameter int WAYS        = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration
    input  logic                             cfg_wr_en,
    input  logic [cht_pkg::CFG_W-1:0]        cfg_wr_data,
    // Input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cht_pkg::in_item_t                s_data,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output cht_pkg::out_item_t               m_data
);

    // Derived widths.
    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int NW  = $clog2(NUM_BUCKETS + 1);
    localparam int CW  = (NW > cht_pkg::CFG_W) ? NW : cht_pkg::CFG_W;
    localparam int IW  = $clog2(WAYS + 1);
    localparam int KD  = NUM_BUCKETS * WAYS;
    localparam int AW  = (KD > 1) ? $clog2(KD) : 1;
    localparam int BXW = (BW > cht_pkg::BUCKET_OUT_W) ? BW : cht_pkg::BUCKET_OUT_W;
    localparam int PXW = (IW > cht_pkg::POS_OUT_W) ? IW : cht_pkg::POS_OUT_W;

    // Sequencer states.
    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_DIV      = 14'b00000000000100,
        S_GETFILL  = 14'b00000000001000,
        S_INS_RD   = 14'b00000000010000,
        S_INS_WR   = 14'b00000000100000,
        S_INS_HEAD = 14'b00000001000000,
        S_SCAN_RD  = 14'b00000010000000,
        S_SCAN_CMP = 14'b00000100000000,
        S_DEL_RD   = 14'b00001000000000,
        S_DEL_WR   = 14'b00010000000000,
        S_DEL_END  = 14'b00100000000000,
        S_DONE     = 14'b01000000000000,
        S_SPARE    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [cht_pkg::CFG_W-1:0]    bcount_reg, bcount_next;
    logic [BW-1:0]                clear_idx_reg, clear_idx_next;
    logic                         m_valid_reg, m_valid_next;
    cht_pkg::out_item_t           m_data_reg, m_data_next;
    cht_pkg::in_item_t            in_reg, in_next;
    logic [BW-1:0]                bucket_reg, bucket_next;
    logic [AW-1:0]                base_reg, base_next;
    logic [IW-1:0]                fill_reg, fill_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [cht_pkg::STATUS_W-1:0] status_reg, status_next;

    // Modulo unit interface.
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_rem;
    logic [CW-1:0] cfg_ext;
    logic [NW-1:0] eff_count;

    // RAM ports.
    logic                      key_we;
    logic [AW-1:0]             key_waddr;
    logic [cht_pkg::KEY_W-1:0] key_wdata;
    logic [AW-1:0]             key_raddr;
    logic [cht_pkg::KEY_W-1:0] key_rdata;
    logic                      fill_we;
    logic [BW-1:0]             fill_waddr;
    logic [IW-1:0]             fill_wdata;
    logic [BW-1:0]             fill_raddr;
    logic [IW-1:0]             fill_rdata;

    logic          is_insert;
    logic          is_delete;
    logic [IW-1:0] idx_inc;
    logic [BXW-1:0] bucket_ext;
    logic [PXW-1:0] pos_ext;

    // Clamp the configured bucket count to 1..NUM_BUCKETS.
    always_comb begin
        cfg_ext = CW'(bcount_reg);
        if (cfg_ext == '0) begin
            eff_count = NW'(1);
        end else if (cfg_ext > CW'(NUM_BUCKETS)) begin
            eff_count = NW'(NUM_BUCKETS);
        end else begin
            eff_count = cfg_ext[NW-1:0];
        end
    end

    assign is_insert  = (in_reg.action == cht_pkg::ACT_INSERT);
    assign is_delete  = (in_reg.action == cht_pkg::ACT_DELETE);
    assign idx_inc    = idx_reg + 1'b1;
    assign bucket_ext = BXW'(bucket_reg);
    assign pos_ext    = PXW'(idx_reg);

    // Modulo unit.
    cht_mod #(
        .DIV_W (NW)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_data.key),
        .divisor   (eff_count),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Key store: WAYS entries per bucket, bucket-major.
    cht_ram #(
        .WIDTH  (cht_pkg::KEY_W),
        .DEPTH  (KD),
        .ADDR_W (AW)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (key_wdata),
        .rd_addr (key_raddr),
        .rd_data (key_rdata)
    );

    // Fill count per bucket.
    cht_ram #(
        .WIDTH  (IW),
        .DEPTH  (NUM_BUCKETS),
        .ADDR_W (BW)
    ) u_fill_ram (
        .aclk    (aclk),
        .wr_en   (fill_we),
        .wr_addr (fill_waddr),
        .wr_data (fill_wdata),
        .rd_addr (fill_raddr),
        .rd_data (fill_rdata)
    );

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        bcount_next    = bcount_reg;
        clear_idx_next = clear_idx_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        in_next        = in_reg;
        bucket_next    = bucket_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;

        div_start  = 1'b0;
        s_ready    = 1'b0;
        key_we     = 1'b0;
        key_waddr  = base_reg + AW'(idx_reg);
        key_wdata  = key_rdata;
        key_raddr  = base_reg + AW'(idx_reg);
        fill_we    = 1'b0;
        fill_waddr = bucket_reg;
        fill_wdata = fill_reg;
        fill_raddr = bucket_reg;

        // Configuration write.
        if (cfg_wr_en) begin
            bcount_next = cfg_wr_data;
        end

        // Result beat taken downstream.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                fill_we        = 1'b1;
                fill_waddr     = clear_idx_reg;
                fill_wdata     = '0;
                clear_idx_next = clear_idx_reg + 1'b1;
                if (clear_idx_reg == BW'(NUM_BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next    = s_data;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                // Fetch the fill count as soon as the bucket is known.
                fill_raddr = BW'(div_rem);
                if (div_done) begin
                    bucket_next = BW'(div_rem);
                    base_next   = AW'(div_rem * WAYS);
                    state_next  = S_GETFILL;
                end
            end
            S_GETFILL: begin
                fill_next = fill_rdata;
                idx_next  = '0;
                if (is_insert) begin
                    if (fill_rdata >= IW'(WAYS)) begin
                        status_next = cht_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end else if (fill_rdata == '0) begin
                        state_next = S_INS_HEAD;
                    end else begin
                        idx_next   = fill_rdata;
                        state_next = S_INS_RD;
                    end
                end else if (fill_rdata == '0) begin
                    status_next = is_delete ? cht_pkg::ST_DEL_FAILED
                                            : cht_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_INS_RD: begin
                key_raddr  = base_reg + AW'(idx_reg - 1'b1);
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                // Move one entry back by one place.
                key_we   = 1'b1;
                idx_next = idx_reg - 1'b1;
                if (idx_reg == IW'(1)) begin
                    state_next = S_INS_HEAD;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_HEAD: begin
                key_we      = 1'b1;
                key_waddr   = base_reg;
                key_wdata   = in_reg.key;
                fill_we     = 1'b1;
                fill_wdata  = fill_reg + 1'b1;
                status_next = cht_pkg::ST_INSERTED;
                state_next  = S_DONE;
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (key_rdata == in_reg.key) begin
                    if (is_delete) begin
                        if (idx_inc < fill_reg) begin
                            state_next = S_DEL_RD;
                        end else begin
                            state_next = S_DEL_END;
                        end
                    end else begin
                        status_next = cht_pkg::ST_FOUND;
                        state_next  = S_DONE;
                    end
                end else if (idx_inc >= fill_reg) begin
                    status_next = is_delete ? cht_pkg::ST_DEL_FAILED
                                            : cht_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_DEL_RD: begin
                key_raddr  = base_reg + AW'(idx_inc);
                state_next = S_DEL_WR;
            end
            S_DEL_WR: begin
                // Move the next entry forward into the gap.
                key_we   = 1'b1;
                idx_next = idx_inc;
                if ((idx_inc + 1'b1) < fill_reg) begin
                    state_next = S_DEL_RD;
                end else begin
                    state_next = S_DEL_END;
                end
            end
            S_DEL_END: begin
                fill_we     = 1'b1;
                fill_wdata  = fill_reg - 1'b1;
                status_next = cht_pkg::ST_DELETED;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.key_echo = in_reg.key;
                    m_data_next.status   = status_reg;
                    m_data_next.bucket   = bucket_ext[cht_pkg::BUCKET_OUT_W-1:0];
                    m_data_next.position = (status_reg == cht_pkg::ST_FOUND)
                                           ? pos_ext[cht_pkg::POS_OUT_W-1:0] : '0;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            bcount_reg    <= cht_pkg::RESET_BUCKET_COUNT;
            clear_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bcount_reg    <= bcount_next;
            clear_idx_reg <= clear_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        in_reg     <= in_next;
        bucket_reg <= bucket_next;
        base_reg   <= base_next;
        fill_reg   <= fill_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
